// ----- src/fcwc_pkg.sv -----
// ----------------------------------------------------------------------------
// Flow color wheel coder package
// Shared constants, pipeline latencies, the arctangent table and the wheel ROM.
// ----------------------------------------------------------------------------
package fcwc_pkg;

    localparam int FLOW_BITS_DEF  = 16;
    localparam logic [15:0] MAX_RADIUS_RST = 16'd256;

    localparam int CORDIC_STEPS = 24;
    localparam int CORDIC_W     = 44;
    localparam int CORDIC_SCALE = 41;
    localparam int SQRT_STEPS   = 32;
    localparam int DIV_STEPS    = 16;

    // Pipeline latencies in cycles.
    localparam int RAD_LAT       = 2 + SQRT_STEPS + DIV_STEPS;
    localparam int COR_LAT       = 1 + CORDIC_STEPS;
    localparam int COLOR_RAD_OFS = 4;
    localparam int COLOR_LAT     = 6;
    localparam int PHASE_DLY     = RAD_LAT - COR_LAT - COLOR_RAD_OFS;
    localparam int TOTAL_LAT     = RAD_LAT + COLOR_LAT - COLOR_RAD_OFS;

    localparam logic [5:0] WHEEL_LAST_K = 6'd53;

    localparam logic [31:0] ATAN_TURN [CORDIC_STEPS] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
        32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
        32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
        32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
        32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
    };

    // Wheel entries packed as {blue, green, red}; unused codes read as black.
    localparam logic [23:0] WHEEL_LUT [64] = '{
        24'h0000FF, 24'h0011FF, 24'h0022FF, 24'h0033FF, 24'h0044FF,
        24'h0055FF, 24'h0066FF, 24'h0077FF, 24'h0088FF, 24'h0099FF,
        24'h00AAFF, 24'h00BBFF, 24'h00CCFF, 24'h00DDFF, 24'h00EEFF,
        24'h00FFFF, 24'h00FFD5, 24'h00FFAA, 24'h00FF80, 24'h00FF55, 24'h00FF2B,
        24'h00FF00, 24'h3FFF00, 24'h7FFF00, 24'hBFFF00,
        24'hFFFF00, 24'hFFE800, 24'hFFD100, 24'hFFBA00, 24'hFFA300, 24'hFF8C00,
        24'hFF7400, 24'hFF5D00, 24'hFF4600, 24'hFF2F00, 24'hFF1800,
        24'hFF0000, 24'hFF0013, 24'hFF0027, 24'hFF003A, 24'hFF004E, 24'hFF0062,
        24'hFF0075, 24'hFF0089, 24'hFF009C, 24'hFF00B0, 24'hFF00C4, 24'hFF00D7,
        24'hFF00EB,
        24'hFF00FF, 24'hD500FF, 24'hAA00FF, 24'h8000FF, 24'h5500FF, 24'h2B00FF,
        24'h000000, 24'h000000, 24'h000000, 24'h000000, 24'h000000,
        24'h000000, 24'h000000, 24'h000000, 24'h000000
    };

endpackage

// ----- src/fcwc_radius.sv -----
// ----------------------------------------------------------------------------
// Flow color wheel coder radius pipeline
// Squared magnitude, pipelined square root and division by the maximum radius.
// ----------------------------------------------------------------------------
module fcwc_radius
    import fcwc_pkg::*;
#(
    parameter int FLOW_BITS = FLOW_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [FLOW_BITS-1:0] flow_x,
    input  logic [FLOW_BITS-1:0] flow_y,
    input  logic [15:0]          max_radius,
    output logic [15:0]          rad
);

    localparam int MAG_W = 2 * FLOW_BITS;
    localparam int CMP_W = (MAG_W > 34) ? MAG_W : 34;

    logic [FLOW_BITS-1:0] ax;
    logic [FLOW_BITS-1:0] ay;
    logic [15:0]          mr;
    logic [MAG_W-1:0]     sqx_next;
    logic [MAG_W-1:0]     sqy_next;
    logic [31:0]          mrsq;
    logic [MAG_W-1:0]     sqx_reg;
    logic [MAG_W-1:0]     sqy_reg;
    logic [33:0]          thr_reg;

    logic [MAG_W-1:0]     mag2;
    logic [CMP_W-1:0]     mag_c;
    logic                 sat_next;
    logic [63:0]          n_next;
    logic [63:0]          n0_reg;
    logic                 sat0_reg;

    logic [63:0] sq_n_reg    [SQRT_STEPS];
    logic [33:0] sq_rem_reg  [SQRT_STEPS];
    logic [31:0] sq_root_reg [SQRT_STEPS];
    logic        sq_sat_reg  [SQRT_STEPS];

    logic [15:0] dv_rem_reg  [DIV_STEPS];
    logic [15:0] dv_q_reg    [DIV_STEPS];
    logic [15:0] dv_lo_reg   [DIV_STEPS];
    logic        dv_sat_reg  [DIV_STEPS];

    assign ax = flow_x[FLOW_BITS-1] ? (~flow_x + 1'b1) : flow_x;
    assign ay = flow_y[FLOW_BITS-1] ? (~flow_y + 1'b1) : flow_y;
    assign mr = (max_radius == 16'd0) ? 16'd1 : max_radius;
    assign sqx_next = ax * ax;
    assign sqy_next = ay * ay;
    assign mrsq = mr * mr;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            sqx_reg <= sqx_next;
            sqy_reg <= sqy_next;
            thr_reg <= {mrsq, 2'b00};
        end
    end

    // Radius of two or more saturates; the root is then skipped by feeding zero.
    assign mag2     = sqx_reg + sqy_reg;
    assign mag_c    = CMP_W'(mag2);
    assign sat_next = (mag_c >= CMP_W'(thr_reg));
    assign n_next   = sat_next ? 64'd0 : {mag_c[33:0], 30'd0};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n0_reg   <= n_next;
            sat0_reg <= sat_next;
        end
    end

    for (genvar j = 0; j < SQRT_STEPS; j++)
    begin : g_sqrt
        logic [63:0] n_in;
        logic [33:0] rem_in;
        logic [31:0] root_in;
        logic        sat_in;
        logic [33:0] rem_sh;
        logic [33:0] trial;
        logic        ge;

        if (j == 0)
        begin : g_first
            assign n_in    = n0_reg;
            assign rem_in  = 34'd0;
            assign root_in = 32'd0;
            assign sat_in  = sat0_reg;
        end
        else
        begin : g_next
            assign n_in    = sq_n_reg[j-1];
            assign rem_in  = sq_rem_reg[j-1];
            assign root_in = sq_root_reg[j-1];
            assign sat_in  = sq_sat_reg[j-1];
        end

        assign rem_sh = {rem_in[31:0], n_in[63-2*j -: 2]};
        assign trial  = {root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                sq_n_reg[j]    <= n_in;
                sq_rem_reg[j]  <= ge ? (rem_sh - trial) : rem_sh;
                sq_root_reg[j] <= {root_in[30:0], ge};
                sq_sat_reg[j]  <= sat_in;
            end
        end
    end

    // The quotient fits 16 bits, so the upper root half is already below mr.
    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        logic [15:0] rem_in;
        logic [15:0] q_in;
        logic [15:0] lo_in;
        logic        sat_in;
        logic [16:0] r;
        logic        ge;

        if (i == 0)
        begin : g_first
            assign rem_in = sq_root_reg[SQRT_STEPS-1][31:16];
            assign q_in   = 16'd0;
            assign lo_in  = sq_root_reg[SQRT_STEPS-1][15:0];
            assign sat_in = sq_sat_reg[SQRT_STEPS-1];
        end
        else
        begin : g_next
            assign rem_in = dv_rem_reg[i-1];
            assign q_in   = dv_q_reg[i-1];
            assign lo_in  = dv_lo_reg[i-1];
            assign sat_in = dv_sat_reg[i-1];
        end

        assign r  = {rem_in, lo_in[15-i]};
        assign ge = (r >= {1'b0, mr});

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                dv_rem_reg[i] <= ge ? 16'(r - {1'b0, mr}) : r[15:0];
                dv_q_reg[i]   <= {q_in[14:0], ge};
                dv_lo_reg[i]  <= lo_in;
                dv_sat_reg[i] <= sat_in;
            end
        end
    end

    assign rad = dv_sat_reg[DIV_STEPS-1] ? 16'hFFFF : dv_q_reg[DIV_STEPS-1];

endmodule

// ----- src/fcwc_cordic.sv -----
// ----------------------------------------------------------------------------
// Flow color wheel coder phase pipeline
// CORDIC vectoring, one rotation per stage, giving the angle as a turn fraction.
// ----------------------------------------------------------------------------
module fcwc_cordic
    import fcwc_pkg::*;
#(
    parameter int FLOW_BITS = FLOW_BITS_DEF
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic [FLOW_BITS-1:0] flow_x,
    input  logic [FLOW_BITS-1:0] flow_y,
    output logic [31:0]          phase
);

    logic signed [CORDIC_W-1:0] sx;
    logic signed [CORDIC_W-1:0] sy;
    logic signed [CORDIC_W-1:0] cx0;
    logic signed [CORDIC_W-1:0] cy0;
    logic                       neg;
    logic                       zero;
    logic signed [CORDIC_W-1:0] px_reg;
    logic signed [CORDIC_W-1:0] py_reg;
    logic [31:0]                pa_reg;
    logic                       pz_reg;

    logic signed [CORDIC_W-1:0] cx_reg  [CORDIC_STEPS];
    logic signed [CORDIC_W-1:0] cy_reg  [CORDIC_STEPS];
    logic [31:0]                ang_reg [CORDIC_STEPS];
    logic                       z_reg   [CORDIC_STEPS];

    assign sx   = {{(CORDIC_W-FLOW_BITS){flow_x[FLOW_BITS-1]}}, flow_x};
    assign sy   = {{(CORDIC_W-FLOW_BITS){flow_y[FLOW_BITS-1]}}, flow_y};
    assign cx0  = sx <<< (CORDIC_SCALE - FLOW_BITS);
    assign cy0  = sy <<< (CORDIC_SCALE - FLOW_BITS);
    assign neg  = sx[CORDIC_W-1];
    assign zero = (flow_x == '0) && (flow_y == '0);

    // Left half plane is folded over by a half turn.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= neg ? -cx0 : cx0;
            py_reg <= neg ? -cy0 : cy0;
            pa_reg <= neg ? 32'h80000000 : 32'h00000000;
            pz_reg <= zero;
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++)
    begin : g_step
        logic signed [CORDIC_W-1:0] x_in;
        logic signed [CORDIC_W-1:0] y_in;
        logic [31:0]                a_in;
        logic                       z_in;
        logic signed [CORDIC_W-1:0] xs;
        logic signed [CORDIC_W-1:0] ys;
        logic                       up;

        if (i == 0)
        begin : g_first
            assign x_in = px_reg;
            assign y_in = py_reg;
            assign a_in = pa_reg;
            assign z_in = pz_reg;
        end
        else
        begin : g_next
            assign x_in = cx_reg[i-1];
            assign y_in = cy_reg[i-1];
            assign a_in = ang_reg[i-1];
            assign z_in = z_reg[i-1];
        end

        assign xs = x_in >>> i;
        assign ys = y_in >>> i;
        assign up = !y_in[CORDIC_W-1] && (y_in != '0);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                cx_reg[i]  <= up ? (x_in + ys) : (x_in - ys);
                cy_reg[i]  <= up ? (y_in - xs) : (y_in + xs);
                ang_reg[i] <= up ? (a_in + ATAN_TURN[i]) : (a_in - ATAN_TURN[i]);
                z_reg[i]   <= z_in;
            end
        end
    end

    assign phase = z_reg[CORDIC_STEPS-1] ? 32'd0 : ang_reg[CORDIC_STEPS-1];

endmodule

// ----- src/fcwc_color.sv -----
// ----------------------------------------------------------------------------
// Flow color wheel coder color pipeline
// Wheel lookup and blend, saturation by radius and conversion to 8-bit channels.
// ----------------------------------------------------------------------------
module fcwc_color
    import fcwc_pkg::*;
(
    input  logic        clk,
    input  logic        en,
    input  logic [31:0] phase,
    input  logic [15:0] rad,
    input  logic        ok,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue
);

    logic [37:0] pos;
    logic [5:0]  k_raw;
    logic [5:0]  k0_reg;
    logic [14:0] f_reg;
    logic [23:0] w0;
    logic [23:0] w1;
    logic [15:0] fw;

    logic [22:0] num_reg  [3];
    logic [22:0] num3_reg [3];
    logic [15:0] q0_reg   [3];
    logic [15:0] col_reg  [3];
    logic [15:0] col5_reg [3];
    logic [7:0]  ch_reg   [3];
    logic        ok5_reg;

    assign pos   = 38'(phase) * 38'd54;
    assign k_raw = pos[37:32];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            k0_reg <= (k_raw > WHEEL_LAST_K) ? WHEEL_LAST_K : k_raw;
            f_reg  <= pos[31:17];
        end
    end

    assign w0 = WHEEL_LUT[k0_reg];
    assign w1 = WHEEL_LUT[k0_reg + 6'd1];
    assign fw = 16'd32768 - {1'b0, f_reg};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ok5_reg <= ok;
        end
    end

    for (genvar c = 0; c < 3; c++)
    begin : g_chan
        logic [22:0] num_next;
        logic [31:0] prod;
        logic [23:0] q255;
        logic [23:0] r;
        logic [15:0] sub;
        logic [31:0] m;
        logic [17:0] c3;
        logic [23:0] t;

        assign num_next = fw * w0[8*c +: 8] + f_reg * w1[8*c +: 8];

        // Division by 255: reciprocal estimate, low by at most one.
        assign prod = {1'b0, num_reg[c], 8'd0} + 32'(num_reg[c]);
        assign q255 = {q0_reg[c], 8'd0} - 24'(q0_reg[c]);
        assign r    = 24'(num3_reg[c]) - q255;

        assign sub = 16'd32768 - col_reg[c];
        assign m   = rad * sub;
        assign c3  = {1'b0, col_reg[c], 1'b0} + 18'(col_reg[c]);

        assign t = {col5_reg[c], 8'd0} - 24'(col5_reg[c]);

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[c]  <= num_next;
                num3_reg[c] <= num_reg[c];
                q0_reg[c]   <= prod[31:16];
                col_reg[c]  <= (r >= 24'd255) ? (q0_reg[c] + 16'd1) : q0_reg[c];
                col5_reg[c] <= (rad <= 16'd32768) ?
                               16'(32'd32768 - (m >> 15)) : c3[17:2];
                ch_reg[c]   <= ok5_reg ? t[22:15] : 8'd0;
            end
        end
    end

    assign red   = ch_reg[0];
    assign green = ch_reg[1];
    assign blue  = ch_reg[2];

endmodule

// ----- src/flow_color_wheel_coder_top.sv -----
// ----------------------------------------------------------------------------
// Flow color wheel coder
// Turns one optical flow vector per request into one color wheel pixel.
// ----------------------------------------------------------------------------
// Usage:
// The slave channel takes one flow vector per request: s_tdata carries
// flow_x and flow_y (signed Q8.8), s_tuser carries flow_valid. A request
// with flow_valid low gives a black pixel. The master channel returns one
// pixel per request in the same order, red, green and blue in m_tdata.
// The normalizing radius (unsigned Q8.8, zero acts as one LSB) is written on
// cfg_we/cfg_wdata while no request is in flight; reset sets it to 1.0.
// Throughput is one request per cycle while the receiver keeps up. The
// squares and saturation registers, 32 square root stages and 16 divider
// stages make up the radius path, and the phase path (24 CORDIC stages) is
// delayed to meet it before the final two color stages.
// All stages advance together. When the receiver holds m_tready low with
// a pixel waiting, the whole pipeline freezes and s_tready drops; nothing
// is lost or repeated. Reset empties the pipeline and sets the radius.
// ----------------------------------------------------------------------------
module flow_color_wheel_coder_top
    import fcwc_pkg::*;
#(
    parameter int FLOW_BITS = FLOW_BITS_DEF
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from the lowest bit: flow_x, flow_y, zero fill.
    input  logic [((2*FLOW_BITS+7)/8)*8-1:0]    s_tdata,
    // Fields from the lowest bit: flow_valid.
    input  logic                                s_tuser,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from the lowest bit: red, green, blue.
    output logic [23:0]                         m_tdata,
    input  logic                                cfg_we,
    input  logic [15:0]                         cfg_wdata
);

    logic                 en;
    logic [FLOW_BITS-1:0] flow_x;
    logic [FLOW_BITS-1:0] flow_y;
    logic [15:0]          max_radius_reg;
    logic [15:0]          rad;
    logic [31:0]          phase;
    logic [7:0]           red;
    logic [7:0]           green;
    logic [7:0]           blue;

    logic        vld_reg [TOTAL_LAT];
    logic        fv_reg  [RAD_LAT];
    logic [31:0] ph_reg  [PHASE_DLY];

    // The pipeline moves whenever the output register is free or being taken.
    assign en       = !vld_reg[TOTAL_LAT-1] || m_tready;
    assign s_tready = en;
    assign m_tvalid = vld_reg[TOTAL_LAT-1];

    assign flow_x = s_tdata[FLOW_BITS-1:0];
    assign flow_y = s_tdata[2*FLOW_BITS-1:FLOW_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_radius_reg <= MAX_RADIUS_RST;
        end
        else if (cfg_we)
        begin
            max_radius_reg <= cfg_wdata;
        end
    end

    // Valid bits run beside the data stages and empty at reset.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < TOTAL_LAT; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            vld_reg[0] <= s_tvalid;
            for (int i = 1; i < TOTAL_LAT; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
        end
    end

    // The flow_valid flag follows the radius path, the phase waits for it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            fv_reg[0] <= s_tuser;
            for (int i = 1; i < RAD_LAT; i++)
            begin
                fv_reg[i] <= fv_reg[i-1];
            end
            ph_reg[0] <= phase;
            for (int i = 1; i < PHASE_DLY; i++)
            begin
                ph_reg[i] <= ph_reg[i-1];
            end
        end
    end

    fcwc_radius #(
        .FLOW_BITS (FLOW_BITS)
    ) u_radius (
        .clk        (clk),
        .en         (en),
        .flow_x     (flow_x),
        .flow_y     (flow_y),
        .max_radius (max_radius_reg),
        .rad        (rad)
    );

    fcwc_cordic #(
        .FLOW_BITS (FLOW_BITS)
    ) u_cordic (
        .clk    (clk),
        .en     (en),
        .flow_x (flow_x),
        .flow_y (flow_y),
        .phase  (phase)
    );

    fcwc_color u_color (
        .clk   (clk),
        .en    (en),
        .phase (ph_reg[PHASE_DLY-1]),
        .rad   (rad),
        .ok    (fv_reg[RAD_LAT-1]),
        .red   (red),
        .green (green),
        .blue  (blue)
    );

    assign m_tdata = {blue, green, red};

endmodule

// ----- dv/flow_color_wheel_coder_check.sv -----
// ----------------------------------------------------------------------------
// Flow color wheel coder checker
// Watches both stream channels and the radius register, works out the pixel
// for every accepted flow vector and compares it with the returned pixel.
// ----------------------------------------------------------------------------
module flow_color_wheel_coder_check
    import fcwc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [31:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SEG_LEN [6] = '{15, 6, 4, 11, 13, 6};

    logic [23:0] pixel_q [$];
    logic [15:0] radius_reg;
    int          pixel_no;

    assign pending = pixel_q.size();

    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n) bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   = n - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // Fraction of a turn from vectoring CORDIC; left half-plane is folded first.
    function automatic logic [31:0] flow_angle(longint x, longint y);
        longint      cx;
        longint      cy;
        longint      t;
        logic [31:0] ang;
        ang = 32'd0;
        if (x == 0 && y == 0)
            return 32'd0;
        cx = x * (64'sd1 <<< 25);
        cy = y * (64'sd1 <<< 25);
        if (cx < 0)
        begin
            cx  = -cx;
            cy  = -cy;
            ang = 32'h80000000;
        end
        for (int i = 0; i < CORDIC_STEPS; i++)
        begin
            if (cy > 0)
            begin
                t   = cx + (cy >>> i);
                cy  = cy - (cx >>> i);
                cx  = t;
                ang = ang + ATAN_TURN[i];
            end
            else
            begin
                t   = cx - (cy >>> i);
                cy  = cy + (cx >>> i);
                cx  = t;
                ang = ang - ATAN_TURN[i];
            end
        end
        return ang;
    endfunction

    // Wheel color at index k as {blue, green, red}, built from segment ramps.
    function automatic logic [23:0] wheel_color(int k);
        int s;
        int i;
        int n;
        int up;
        int dn;
        s = 0;
        i = k;
        while (s < 5 && i >= SEG_LEN[s])
        begin
            i = i - SEG_LEN[s];
            s++;
        end
        n = SEG_LEN[s];
        if (i >= n)
            i = n - 1;
        up = 255 * i / n;
        dn = 255 - up;
        case (s)
            0:       return {8'd0, up[7:0], 8'd255};
            1:       return {8'd0, 8'd255, dn[7:0]};
            2:       return {up[7:0], 8'd255, 8'd0};
            3:       return {8'd255, dn[7:0], 8'd0};
            4:       return {8'd255, 8'd0, up[7:0]};
            default: return {dn[7:0], 8'd0, 8'd255};
        endcase
    endfunction

    function automatic logic [23:0] coded_pixel(logic [15:0] fx, logic [15:0] fy,
                                                logic ok, logic [15:0] mr_in);
        longint          x;
        longint          y;
        longint unsigned ax;
        longint unsigned ay;
        longint unsigned mag2;
        longint unsigned mr;
        longint unsigned rad;
        longint unsigned pos;
        longint unsigned col;
        longint unsigned f;
        logic [31:0]     ang;
        int              k0;
        int              k1;
        logic [23:0]     w0;
        logic [23:0]     w1;
        logic [23:0]     pix;
        if (!ok)
            return 24'd0;
        x    = longint'(signed'(fx));
        y    = longint'(signed'(fy));
        ax   = (x < 0) ? -x : x;
        ay   = (y < 0) ? -y : y;
        mag2 = ax * ax + ay * ay;
        mr   = (mr_in == 0) ? 1 : mr_in;
        if (mag2 >= 4 * mr * mr)
            rad = 65535;
        else
        begin
            rad = int_sqrt(mag2 << 30) / mr;
            if (rad > 65535)
                rad = 65535;
        end
        ang = flow_angle(x, y);
        pos = longint'(ang) * 54;
        k0  = int'(pos >> 32);
        if (k0 > 53)
            k0 = 53;
        k1  = (k0 + 1) % 55;
        f   = (pos >> 17) & 64'h7FFF;
        w0  = wheel_color(k0);
        w1  = wheel_color(k1);
        for (int c = 0; c < 3; c++)
        begin
            col = ((32768 - f) * w0[8*c +: 8] + f * w1[8*c +: 8]) / 255;
            if (rad <= 32768)
                col = 32768 - ((rad * (32768 - col)) >> 15);
            else
                col = (col * 3) >> 2;
            pix[8*c +: 8] = 8'((255 * col) >> 15);
        end
        return pix;
    endfunction

    task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
        errors++;
        $display("ERROR pixel %0d: %s is %0d, predicted %0d", pixel_no, what, got, want);
    endtask

    initial errors = 0;

    always @(posedge clk or negedge rst_n)
    begin
        logic [23:0] want;
        if (!rst_n)
        begin
            pixel_q.delete();
            radius_reg = MAX_RADIUS_RST;
            pixel_no   = 0;
        end
        else
        begin
            // Users write the register only with no request in flight; unchecked.
            if (cfg_we)
                radius_reg = cfg_wdata;
            if (s_tvalid && s_tready)
                pixel_q.insert(pixel_q.size(),
                               coded_pixel(s_tdata[15:0], s_tdata[31:16], s_tuser,
                                           radius_reg));
            if (m_tvalid && m_tready)
            begin
                if (pixel_q.size() == 0)
                begin
                    errors++;
                    $display("ERROR pixel %0d arrived with no request waiting", pixel_no);
                end
                else
                begin
                    want = pixel_q.pop_front();
                    if (m_tdata[7:0] !== want[7:0])
                        report_mismatch("red", m_tdata[7:0], want[7:0]);
                    if (m_tdata[15:8] !== want[15:8])
                        report_mismatch("green", m_tdata[15:8], want[15:8]);
                    if (m_tdata[23:16] !== want[23:16])
                        report_mismatch("blue", m_tdata[23:16], want[23:16]);
                end
                pixel_no++;
            end
        end
    end

endmodule

// ----- dv/flow_color_wheel_coder_top_test.sv -----
// ----------------------------------------------------------------------------
// Flow color wheel coder testbench
// Drives flow vectors through the coder under several radius settings, with
// random gaps and stalls, and leaves prediction and comparison to the checker.
// ----------------------------------------------------------------------------
module flow_color_wheel_coder_top_test
    import fcwc_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    // Settling wait after the last pixel, with a margin over the pipeline depth.
    localparam int DRAIN_CYCLES = TOTAL_LAT + 20;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 1950;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [31:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [23:0] m_tdata;
    logic        cfg_we;
    logic [15:0] cfg_wdata;

    int          errors;
    int          pending;
    int          cycles;
    int          sent;
    // When calm is set neither side idles; hold_rx asks for a long stall.
    logic        calm;
    logic        hold_rx;
    logic [15:0] radius_now;

    flow_color_wheel_coder_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    flow_color_wheel_coder_check CHECK
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .errors    (errors),
        .pending   (pending)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    // Run watchdog: a hung handshake ends the run as a failure.
    initial cycles = 0;
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d pixels outstanding", cycles, pending);
            $display("Mismatches found");
            $finish;
        end
    end

    // Receiver: random stalls, none while calm, and one long hold-off on request.
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_rx)
            begin
                m_tready <= 1'b0;
                for (int n = 0; n < 400; n++)
                    @(posedge clk);
                hold_rx = 1'b0;
                m_tready <= 1'b1;
            end
            else
                m_tready <= calm || ($urandom_range(99) >= 18);
        end
    end

    // One request: raise valid at the edge, then wait for an edge where the
    // block is ready. Ready is sampled at the falling edge, where it is stable.
    task automatic send_flow(logic [15:0] fx, logic [15:0] fy, logic ok);
        logic rdy;
        int   gap;
        if (!calm && $urandom_range(99) < 18)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 6);
            for (int n = 0; n < gap; n++)
                @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {fy, fx};
        s_tuser  <= ok;
        forever
        begin
            @(negedge clk);
            rdy = s_tready;
            @(posedge clk);
            if (rdy)
                break;
        end
        sent++;
    endtask

    task automatic drain_all();
        s_tvalid <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        for (int n = 0; n < DRAIN_CYCLES; n++)
            @(posedge clk);
    endtask

    // The radius is only changed once the pipeline is empty.
    task automatic set_radius(logic [15:0] value);
        drain_all();
        cfg_we     <= 1'b1;
        cfg_wdata  <= value;
        radius_now = value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // Random vector: mostly around the current radius so that both the
    // fade-from-white branch and the beyond-unit branch are reached.
    task automatic send_random();
        logic [15:0] fx;
        logic [15:0] fy;
        int          span;
        int          pick;
        pick = $urandom_range(99);
        if (pick < 30)
        begin
            fx = 16'($urandom);
            fy = 16'($urandom);
        end
        else
        begin
            span = (radius_now == 0) ? 4 : 3 * int'(radius_now);
            if (span > 32767)
                span = 32767;
            if (pick < 40)
                span = 8;
            fx = 16'($urandom_range(2 * span) - span);
            fy = 16'($urandom_range(2 * span) - span);
        end
        send_flow(fx, fy, $urandom_range(99) >= 10);
    endtask

    task automatic send_directed();
        send_flow(16'h0000, 16'h0000, 1'b1);
        send_flow(16'($urandom), 16'($urandom), 1'b0);
        send_flow(16'hFFFF, 16'hFFFF, 1'b0);
        send_flow(16'h7FFF, 16'h0000, 1'b1);
        send_flow(16'h8000, 16'h0000, 1'b1);
        send_flow(16'h0000, 16'h7FFF, 1'b1);
        send_flow(16'h0000, 16'h8000, 1'b1);
        send_flow(16'h7FFF, 16'h7FFF, 1'b1);
        send_flow(16'h8000, 16'h8000, 1'b1);
        send_flow(16'h7FFF, 16'h8000, 1'b1);
        send_flow(16'h8000, 16'h7FFF, 1'b1);
        send_flow(16'h0100, 16'h0000, 1'b1);
        send_flow(16'h0000, 16'hFF00, 1'b1);
        send_flow(16'hFF80, 16'h0080, 1'b1);
        send_flow(16'h00B5, 16'h00B5, 1'b1);
        send_flow(16'h0001, 16'hFFFF, 1'b1);
        send_flow(16'hFFFF, 16'h0000, 1'b1);
        send_flow(16'h0200, 16'h0001, 1'b1);
        send_flow(16'hFE00, 16'hFFFF, 1'b1);
    endtask

    initial
    begin
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = 1'b0;
        cfg_we     = 1'b0;
        cfg_wdata  = '0;
        calm       = 1'b0;
        hold_rx    = 1'b0;
        sent       = 0;
        radius_now = MAX_RADIUS_RST;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset radius of 1.0 first, then the directed vectors under extremes.
        send_directed();
        set_radius(16'd0);
        send_directed();
        set_radius(16'd1);
        send_directed();
        set_radius(16'hFFFF);
        send_directed();

        set_radius(16'd256);
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            send_random();

        // Receiver holds off long enough that the pipeline fills and stalls.
        hold_rx = 1'b1;
        for (int i = 0; i < 120; i++)
            send_random();

        // Sender pauses until every pixel is back.
        drain_all();
        calm = 1'b1;
        for (int i = 0; i < 200; i++)
            send_random();
        calm = 1'b0;

        set_radius(16'($urandom_range(2, 4000)));
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            send_random();
        set_radius(16'($urandom_range(4000, 65534)));
        for (int i = 0; i < RANDOM_ITEMS / 4; i++)
            send_random();
        set_radius(16'd1);
        for (int i = 0; i < 100; i++)
            send_random();

        drain_all();
        $display("Coded %0d flow vectors under radius settings 1.0, 0, 1, 65535 and random,",
                 sent);
        $display("with zero, invalid, axis and saturating vectors and a long receiver stall.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
